// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the position keeper rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/pkmtm_pkg.sv =====
// shared constants and types for the position keeper
// no dependencies
package pkmtm_pkg;
   localparam int unsigned QTY_W   = 32;
   localparam int unsigned PRICE_W = 32;
   localparam int unsigned MONEY_W = 64;
   localparam int unsigned ACC_W   = 72;
   // entry word: quantity, cost, market price, price known
   localparam int unsigned ENTRY_W = QTY_W + PRICE_W + PRICE_W + 1;
   localparam logic KIND_FILL  = 1'b0;
   localparam logic KIND_PRICE = 1'b1;

   typedef struct packed {
      logic signed [QTY_W-1:0] qty;
      logic [PRICE_W-1:0]      cost;
      logic [PRICE_W-1:0]      mkt;
      logic                    known;
   } entry_type;

   // saturate a wide signed value to 64 bits
   function automatic logic signed [MONEY_W-1:0] sat64(input logic signed [ACC_W-1:0] v);
      logic signed [MONEY_W-1:0] r;
      r = v[MONEY_W-1:0];
      if (v > $signed({{(ACC_W-MONEY_W){1'b0}}, 1'b0, {(MONEY_W-1){1'b1}}}))
         r = {1'b0, {(MONEY_W-1){1'b1}}};
      else if (v < $signed({{(ACC_W-MONEY_W+1){1'b1}}, {(MONEY_W-1){1'b0}}}))
         r = {1'b1, {(MONEY_W-1){1'b0}}};
      return r;
   endfunction
endpackage

// ===== rtl/core/pkmtm_ram.sv =====
// generic single port ram with registered read
// no dependencies
module pkmtm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== rtl/core/pkmtm_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on nothing
module pkmtm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [95:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [95:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;

   // shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[32:0], quo_ff[95]};
      done    = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 7'd96;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[94:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[94:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   assign quotient = quo_in[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule

// ===== rtl/core/position_keeper_mark_to_market.sv =====
// position keeper with average cost and mark-to-market equity
// a request walks read, multiply, calc, an optional divide for a same-side fill, write (skipped
// for an out-of-range instrument), then the equity sweep over the entry ram, one entry a cycle,
// and done; a new request is taken only in idle, after the previous result is loaded
// reset and starting_cash writes run a clearing sweep that zeroes every entry
// depends on pkmtm_pkg, pkmtm_ram, pkmtm_div, assert_macros.svh
`include "assert_macros.svh"
module position_keeper_mark_to_market #(
   parameter int unsigned NUM_INSTRUMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic signed [63:0] csr_starting_cash,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [5:0]         req_instrument,
   input  logic [31:0]        req_price,
   input  logic signed [31:0] req_trade_quantity,
   input  logic [31:0]        req_commission,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_cash_now,
   output logic signed [63:0] rsp_equity_now,
   output logic signed [31:0] rsp_position_now,
   output logic [31:0]        rsp_average_cost_now
);
   localparam int unsigned AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
   localparam logic [AW:0] LAST = (AW+1)'(NUM_INSTRUMENTS - 1);
   localparam int unsigned ACC_W = pkmtm_pkg::ACC_W;
   localparam int unsigned ENTRY_BITS = pkmtm_pkg::ENTRY_W;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_CALC  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_WRITE = 4'd5;
   localparam logic [3:0] ST_SWEEP = 4'd6;
   localparam logic [3:0] ST_ACC   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;
   localparam logic [3:0] ST_MUL   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [AW:0] ptr_ff, ptr_in;
   logic signed [63:0] cash_ff, cash_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic prod_v_ff, prod_v_in;
   logic kind_ff; logic [5:0] inst_ff; logic [31:0] price_ff, comm_ff;
   logic signed [31:0] tq_ff;
   logic valid_idx_ff;
   pkmtm_pkg::entry_type ent_ff, ent_in, rd_ent, wr_ent;
   logic signed [63:0] pq_ff, pq_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [63:0] rc_ff, re_ff; logic signed [31:0] rp_ff; logic [31:0] ra_ff;
   logic ram_we; logic [AW-1:0] ram_addr;
   logic [ENTRY_BITS-1:0] rd_raw;
   logic div_start, div_done; logic [95:0] div_num; logic [32:0] div_den;
   logic [31:0] div_q;
   logic [32:0] ap, at;
   logic signed [32:0] nq;
   logic signed [63:0] pxq;

   assign rd_ent = pkmtm_pkg::entry_type'(rd_raw);

   pkmtm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(NUM_INSTRUMENTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ENTRY_BITS'(wr_ent)), .rd_data(rd_raw));

   pkmtm_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q));

   assign ap = pq_ff[32] ? 33'(-pq_ff) : pq_ff[32:0];
   assign at = tq_ff[31] ? 33'(-{tq_ff[31], tq_ff}) : {1'b0, tq_ff};
   assign nq = 33'(pq_ff) + 33'(tq_ff);
   assign div_num = 96'(ap) * 96'(ent_ff.cost) + 96'(at) * 96'(price_ff);
   assign div_den = 33'(ap + at);
   assign pxq = $signed({{32{tq_ff[31]}}, tq_ff}) * $signed({32'd0, price_ff});

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cash_in   = cash_ff;
      acc_in    = acc_ff;
      ent_in    = ent_ff;
      pq_in     = pq_ff;
      prod_in   = prod_ff;
      prod_v_in = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = ptr_ff[AW-1:0];
      wr_ent    = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            ram_addr = AW'(req_instrument);
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            ram_addr = AW'(inst_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ent_in  = rd_ent;
            pq_in   = 64'(rd_ent.qty);
            prod_in = pxq;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            ram_addr = AW'(inst_ff);
            if (!valid_idx_ff) begin
               state_in = ST_SWEEP;
               ptr_in = '0;
            end else if (kind_ff == pkmtm_pkg::KIND_PRICE) begin
               ent_in.mkt = price_ff;
               ent_in.known = 1'b1;
               state_in = ST_WRITE;
            end else begin
               cash_in = pkmtm_pkg::sat64(ACC_W'(cash_ff) - ACC_W'(prod_ff)
                                          - ACC_W'({1'b0, comm_ff}));
               if (nq > 33'sh0_7FFF_FFFF) ent_in.qty = 32'h7FFF_FFFF;
               else if (nq < -33'sh0_8000_0000) ent_in.qty = 32'h8000_0000;
               else ent_in.qty = nq[31:0];
               if (pq_ff == 0) begin
                  ent_in.cost = price_ff;
                  state_in = ST_WRITE;
               end else if ((pq_ff > 0 && tq_ff > 0) || (pq_ff < 0 && tq_ff < 0)) begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ent_in.cost = div_q;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_addr = AW'(inst_ff);
            ram_we = 1'b1;
            wr_ent = ent_ff;
            ptr_in = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            acc_in = ACC_W'(cash_ff);
            ram_addr = '0;
            ptr_in = (AW+1)'(1);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // read next entry, multiply last read, add previous product
            if (prod_v_ff) acc_in = acc_ff + ACC_W'(prod_ff);
            if (ptr_ff <= (LAST + 1'b1)) begin
               prod_in = $signed({{32{rd_ent.qty[31]}}, rd_ent.qty})
                  * $signed({32'd0, rd_ent.known ? rd_ent.mkt : rd_ent.cost});
               prod_v_in = (rd_ent.qty != 0);
               ram_addr = ptr_ff[AW-1:0];
               ptr_in = ptr_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write_enable) begin
         state_in = ST_CLEAR;
         ptr_in = '0;
         cash_in = csr_starting_cash;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !csr_write_enable;

   // result register load and valid
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         cash_ff      <= 64'sd1000000000;
         rsp_valid_ff <= 1'b0;
         prod_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cash_ff      <= cash_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff  <= acc_in;
      ent_ff  <= ent_in;
      pq_ff   <= pq_in;
      prod_ff <= prod_in;
      if (req_valid && req_ready) begin
         kind_ff      <= req_kind;
         inst_ff      <= req_instrument;
         price_ff     <= req_price;
         tq_ff        <= req_trade_quantity;
         comm_ff      <= req_commission;
         valid_idx_ff <= (32'(req_instrument) < NUM_INSTRUMENTS);
      end
      if (rsp_load) begin
         rc_ff <= cash_ff;
         re_ff <= pkmtm_pkg::sat64(acc_ff);
         rp_ff <= valid_idx_ff ? ent_ff.qty : 32'sd0;
         ra_ff <= (valid_idx_ff && ent_ff.qty != 0) ? ent_ff.cost : 32'd0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cash_now         = rc_ff;
   assign rsp_equity_now       = re_ff;
   assign rsp_position_now     = rp_ff;
   assign rsp_average_cost_now = ra_ff;

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_clear_after_cfg, clock, reset, csr_write_enable, state_ff == ST_CLEAR)
   `ASSERT_IMPLIES(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !ram_we)
endmodule

// ===== dv/testbench.sv =====
// testbench for the position keeper: drives fills and price updates, predicts results
// depends on pkmtm_pkg and position_keeper_mark_to_market
`timescale 1ns / 1ps
module testbench;

   // ledger predictor and queue of expected results
   class ledger_board;
      logic signed [63:0] cash;
      logic signed [31:0] qty [64];
      logic [31:0]        cost [64];
      logic [31:0]        mkt [64];
      bit                 known [64];
      logic signed [63:0] exp_cash [$];
      logic signed [63:0] exp_equity [$];
      logic signed [31:0] exp_pos [$];
      logic [31:0]        exp_avg [$];
      int                 errors;

      function void restart(logic signed [63:0] c);
         cash = c;
         foreach (qty[i]) begin
            qty[i] = 0;
            cost[i] = 0;
            mkt[i] = 0;
            known[i] = 0;
         end
      endfunction

      function logic signed [63:0] sat(logic signed [127:0] v);
         if (v > 128'sh7fffffffffffffff) return 64'sh7fffffffffffffff;
         if (v < -128'sh8000000000000000) return 64'sh8000000000000000;
         return v[63:0];
      endfunction

      // note an accepted transaction and compute its expected result
      function void note_request(logic k, logic [5:0] ix, logic [31:0] pr,
                                 logic signed [31:0] tq, logic [31:0] cm);
         logic signed [127:0] acc;
         logic signed [63:0]  pq, nq;
         logic [63:0]         ap, at, total;
         if (k == pkmtm_pkg::KIND_FILL) begin
            acc = $signed({{64{cash[63]}}, cash}) - 128'(tq) * $signed({96'd0, pr})
                  - $signed({96'd0, cm});
            cash = sat(acc);
            pq = qty[ix];
            if (pq == 0) cost[ix] = pr;
            else if ((pq > 0 && tq > 0) || (pq < 0 && tq < 0)) begin
               ap = pq < 0 ? -pq : pq;
               at = tq < 0 ? -64'(tq) : 64'(tq);
               total = ap * cost[ix] + at * pr;
               cost[ix] = 32'(total / (ap + at));
            end
            nq = pq + 64'(tq);
            if (nq > 64'sh7fffffff) nq = 64'sh7fffffff;
            if (nq < -64'sh80000000) nq = -64'sh80000000;
            qty[ix] = nq[31:0];
         end else begin
            mkt[ix] = pr;
            known[ix] = 1;
         end
         acc = $signed({{64{cash[63]}}, cash});
         foreach (qty[i])
            if (qty[i] != 0)
               acc += 128'(qty[i]) * $signed({96'd0, known[i] ? mkt[i] : cost[i]});
         exp_cash.push_back(cash);
         exp_equity.push_back(sat(acc));
         exp_pos.push_back(qty[ix]);
         exp_avg.push_back(qty[ix] != 0 ? cost[ix] : 32'd0);
      endfunction

      // compare a result with the oldest expectation
      function void check_result(logic signed [63:0] c, logic signed [63:0] e,
                                 logic signed [31:0] p, logic [31:0] a);
         if (exp_cash.size() == 0) begin
            $error("unexpected result");
            errors++;
            return;
         end
         if (c !== exp_cash[0]) begin
            $error("cash_now expected %0d got %0d", exp_cash[0], c); errors++;
         end
         if (e !== exp_equity[0]) begin
            $error("equity_now expected %0d got %0d", exp_equity[0], e); errors++;
         end
         if (p !== exp_pos[0]) begin
            $error("position_now expected %0d got %0d", exp_pos[0], p); errors++;
         end
         if (a !== exp_avg[0]) begin
            $error("average_cost_now expected %0d got %0d", exp_avg[0], a); errors++;
         end
         void'(exp_cash.pop_front());
         void'(exp_equity.pop_front());
         void'(exp_pos.pop_front());
         void'(exp_avg.pop_front());
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_write_enable = 0;
   logic signed [63:0] csr_starting_cash = 0;
   logic req_valid = 0, req_ready, req_kind = 0;
   logic [5:0] req_instrument = 0;
   logic [31:0] req_price = 0, req_commission = 0;
   logic signed [31:0] req_trade_quantity = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [63:0] rsp_cash_now, rsp_equity_now;
   logic signed [31:0] rsp_position_now;
   logic [31:0] rsp_average_cost_now;
   int send_idle = 0, recv_idle = 0;
   ledger_board board;

   always #1 clock = ~clock;

   position_keeper_mark_to_market u_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_starting_cash(csr_starting_cash),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_instrument(req_instrument), .req_price(req_price),
      .req_trade_quantity(req_trade_quantity), .req_commission(req_commission),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cash_now(rsp_cash_now),
      .rsp_equity_now(rsp_equity_now), .rsp_position_now(rsp_position_now),
      .rsp_average_cost_now(rsp_average_cost_now)
   );

   // sample transactions at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_kind, req_instrument, req_price,
                            req_trade_quantity, req_commission);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_cash_now, rsp_equity_now, rsp_position_now,
                            rsp_average_cost_now);
   end

   // receiver stalls
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   // optionally idle, then send one transaction; valid drops while idling
   task automatic send(logic k, logic [5:0] ix, logic [31:0] pr,
                       logic signed [31:0] tq, logic [31:0] cm);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_instrument <= ix;
      req_price <= pr;
      req_trade_quantity <= tq;
      req_commission <= cm;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.exp_cash.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_cash(logic signed [63:0] c);
      drain();
      csr_write_enable <= 1;
      csr_starting_cash <= c;
      @(negedge clock);
      csr_write_enable <= 0;
      board.restart(c);
   endtask

   // random mix: a few hot instruments so positions build up
   task automatic random_items(int n);
      logic [31:0] pr;
      logic signed [31:0] tq;
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         pr = r < 10 ? $urandom() : $urandom_range(2000000, 1);
         tq = r < 10 ? $urandom() : $signed($urandom_range(2000)) - 1000;
         send($urandom_range(99) < 25,
              $urandom_range(99) < 80 ? 6'($urandom_range(7)) : 6'($urandom()),
              pr, tq, r < 10 ? $urandom() : $urandom_range(500));
      end
   endtask

   initial begin
      board = new();
      board.restart(64'sd1000000000);
      repeat (12) @(negedge clock);
      reset <= 0;
      // directed: extremes and special cases
      send(pkmtm_pkg::KIND_FILL, 0, 32'd0, 32'sd0, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd150000, 32'sd0, 32'd7);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd150000, 32'sd100, 32'd5);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd170001, 32'sd33, 32'd5);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd90000, -32'sd50, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd90000, 32'sd0, 32'd1);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd80000, -32'sd200, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 1, 32'd70000, -32'sd9, 32'd0);
      send(pkmtm_pkg::KIND_PRICE, 1, 32'd123456, 32'sd0, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 63, 32'hffffffff, 32'sh7fffffff, 32'hffffffff);
      send(pkmtm_pkg::KIND_FILL, 63, 32'hffffffff, 32'sh7fffffff, 32'hffffffff);
      send(pkmtm_pkg::KIND_PRICE, 63, 32'hffffffff, 32'sd0, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 62, 32'hffffffff, 32'sh80000000, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 62, 32'hffffffff, 32'sh80000000, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 62, 32'd1, 32'sh7fffffff, 32'd0);
      send(pkmtm_pkg::KIND_PRICE, 5, 32'd0, 32'sh80000000, 32'hffffffff);
      write_cash(64'sh7fffffffffffffff);
      send(pkmtm_pkg::KIND_FILL, 2, 32'hffffffff, -32'sd5, 32'd0);
      send(pkmtm_pkg::KIND_FILL, 2, 32'd1, 32'sh80000000, 32'd0);
      write_cash(64'sh8000000000000000);
      send(pkmtm_pkg::KIND_FILL, 3, 32'hffffffff, 32'sd5, 32'hffffffff);
      send(pkmtm_pkg::KIND_FILL, 3, 32'hffffffff, 32'sh7fffffff, 32'd0);
      write_cash(64'sd0);
      // random phases with different idling
      send_idle = 23; recv_idle = 81;
      random_items(130);
      drain();
      write_cash($signed({$urandom(), $urandom()}));
      send_idle = 81; recv_idle = 23;
      random_items(130);
      write_cash(64'sd1000000000);
      send_idle = 0; recv_idle = 0;
      random_items(140);
      drain();
      if (board.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end
endmodule
